// ----- rtl/core/srm_pkg.sv -----
// Shared types and constants for the stack with remove-minimum block.
// No dependencies; every other file in rtl/core refers to this package.
package srm_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ACT_PUSH   = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_START,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0]     removed_value;
    status_t              status;
    logic [CNT_OUT_W-1:0] count;
  } result_t;

endpackage

// ----- rtl/core/srm_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
// Depends on srm_pkg for field widths.
interface srm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [srm_pkg::VAL_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface srm_out_if;
  logic                          valid;
  logic                          ready;
  logic [srm_pkg::VAL_W-1:0]     removed_value;
  logic [1:0]                    status;
  logic [srm_pkg::CNT_OUT_W-1:0] count;

  modport source (output valid, output removed_value, output status, output count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input count,
                  output ready);
endinterface

// ----- rtl/core/stack_with_remove_minimum.sv -----
// Top level of the bounded stack with remove-minimum.
// Depends on srm_pkg, srm_if, srm_store and srm_seq.
//
//   channel   dir   payload                          beat when
//   in_ch     in    action, value                    valid && ready
//   out_ch    out   removed_value, status, count     valid && ready
//
// A push or a remove on empty goes straight to the finish step; a remove on n entries
// scans all n entries for the minimum at position p, one scan read a cycle, then shifts
// the n - 1 - p entries above it down, one read and one write a cycle, before it
// finishes. The result loads into the output register in the finish step.
// Reset clears the state, the entry count and the output valid flag; the memory needs no clearing.
// A new beat is taken while a result waits in the output register; a stalled
// result holds the finish step until the register frees.
module stack_with_remove_minimum #(
  parameter int DEPTH = srm_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  srm_in_if.sink     in_ch,
  srm_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);

  logic                      res_free;
  logic                      res_load;
  srm_pkg::result_t          res;
  srm_pkg::result_t          out_res_r;
  logic                      out_valid_r;
  logic                      mem_wr_en;
  logic [AW-1:0]             mem_wr_addr;
  logic [srm_pkg::VAL_W-1:0] mem_wr_data;
  logic                      mem_rd_en;
  logic [AW-1:0]             mem_rd_addr;
  logic [srm_pkg::VAL_W-1:0] mem_rd_data;

  srm_seq #(.DEPTH(DEPTH)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_action   (in_ch.action),
    .in_value    (in_ch.value),
    .res_free    (res_free),
    .res_load    (res_load),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  srm_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_res_r.removed_value;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.count         = out_res_r.count;

endmodule

// ----- rtl/core/srm_store.sv -----
// Entry memory: one write port and one read port with registered read data.
// Depends on srm_pkg for the value width.
module srm_store #(
  parameter int DEPTH = srm_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [srm_pkg::VAL_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [srm_pkg::VAL_W-1:0] rd_data
);

  logic [srm_pkg::VAL_W-1:0] mem [DEPTH];
  logic [srm_pkg::VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/srm_seq.sv -----
// Sequencer: takes one beat, writes a push, or for a remove scans for the minimum and
// shifts the upper entries down over it. Depends on srm_pkg.
module srm_seq #(
  parameter int DEPTH = srm_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [srm_pkg::VAL_W-1:0] in_value,
  input  logic                      res_free,
  output logic                      res_load,
  output srm_pkg::result_t          res,
  output logic                      mem_wr_en,
  output logic [AW-1:0]             mem_wr_addr,
  output logic [srm_pkg::VAL_W-1:0] mem_wr_data,
  output logic                      mem_rd_en,
  output logic [AW-1:0]             mem_rd_addr,
  input  logic [srm_pkg::VAL_W-1:0] mem_rd_data
);

  srm_pkg::state_t           state_r,  state_nxt;
  logic [CW-1:0]             cnt_r,    cnt_nxt;
  srm_pkg::status_t          status_r, status_nxt;
  srm_pkg::action_t          act_r,    act_nxt;
  logic [srm_pkg::VAL_W-1:0] best_r,   best_nxt;
  logic [AW-1:0]             pos_r,    pos_nxt;
  logic [AW-1:0]             idx_r,    idx_nxt;

  logic          accept;
  logic          not_full;
  logic          scan_last;
  logic          take;
  logic          no_shift;
  logic          shift_more;
  logic [CW-1:0] cnt_fin;
  logic [CW+srm_pkg::CNT_OUT_W-1:0] cnt_ext;

  assign accept     = in_valid && (state_r == srm_pkg::S_IDLE);
  assign not_full   = cnt_r < CW'(DEPTH);
  assign scan_last  = CW'(idx_r) == (cnt_r - CW'(1));
  // first entry always loads the running minimum; later ones only if strictly smaller
  assign take       = (idx_r == '0) || ($signed(mem_rd_data) < $signed(best_r));
  assign no_shift   = (CW'(pos_r) + CW'(1)) == cnt_r;
  assign shift_more = ((CW+1)'(idx_r) + (CW+1)'(2)) < (CW+1)'(cnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srm_pkg::S_IDLE: begin
        if (accept) begin
          if (in_action == srm_pkg::ACT_REMOVE && cnt_r != '0) begin
            state_nxt = srm_pkg::S_SCAN;
          end else begin
            state_nxt = srm_pkg::S_FINISH;
          end
        end
      end
      srm_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = srm_pkg::S_SHIFT_START;
        end
      end
      srm_pkg::S_SHIFT_START: begin
        state_nxt = no_shift ? srm_pkg::S_FINISH : srm_pkg::S_SHIFT;
      end
      srm_pkg::S_SHIFT: begin
        if (!shift_more) begin
          state_nxt = srm_pkg::S_FINISH;
        end
      end
      srm_pkg::S_FINISH: begin
        if (res_free) begin
          state_nxt = srm_pkg::S_IDLE;
        end
      end
      default: state_nxt = srm_pkg::S_IDLE;
    endcase
  end

  // Count after this item, for the result and the count register
  always_comb begin
    cnt_fin = cnt_r;
    if (status_r == srm_pkg::ST_OK) begin
      cnt_fin = (act_r == srm_pkg::ACT_PUSH) ? cnt_r + CW'(1) : cnt_r - CW'(1);
    end
  end

  // Datapath next values
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    act_nxt    = act_r;
    best_nxt   = best_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      srm_pkg::S_IDLE: begin
        if (accept) begin
          act_nxt = srm_pkg::action_t'(in_action);
          idx_nxt = '0;
          if (in_action == srm_pkg::ACT_PUSH) begin
            status_nxt = not_full ? srm_pkg::ST_OK : srm_pkg::ST_FULL;
          end else begin
            status_nxt = (cnt_r == '0) ? srm_pkg::ST_EMPTY : srm_pkg::ST_OK;
          end
        end
      end
      srm_pkg::S_SCAN: begin
        if (take) begin
          best_nxt = mem_rd_data;
          pos_nxt  = idx_r;
        end
        idx_nxt = idx_r + AW'(1);
      end
      srm_pkg::S_SHIFT_START: begin
        idx_nxt = pos_r;
      end
      srm_pkg::S_SHIFT: begin
        idx_nxt = idx_r + AW'(1);
      end
      srm_pkg::S_FINISH: begin
        if (res_free) begin
          cnt_nxt = cnt_fin;
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = (state_r == srm_pkg::S_IDLE);
    res_load    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    unique case (state_r)
      srm_pkg::S_IDLE: begin
        if (accept && in_action == srm_pkg::ACT_PUSH && not_full) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cnt_r[AW-1:0];
          mem_wr_data = in_value;
        end
        // prime the scan with the bottom entry
        mem_rd_en = accept && (in_action == srm_pkg::ACT_REMOVE);
      end
      srm_pkg::S_SCAN: begin
        mem_rd_en   = !scan_last;
        mem_rd_addr = idx_r + AW'(1);
      end
      srm_pkg::S_SHIFT_START: begin
        mem_rd_en   = !no_shift;
        mem_rd_addr = pos_r + AW'(1);
      end
      srm_pkg::S_SHIFT: begin
        // drop entry idx+1 into idx, fetch the next source
        mem_wr_en   = 1'b1;
        mem_rd_en   = shift_more;
        mem_rd_addr = idx_r + AW'(2);
      end
      srm_pkg::S_FINISH: begin
        res_load = res_free;
      end
      default: ;
    endcase
  end

  assign cnt_ext = {{srm_pkg::CNT_OUT_W{1'b0}}, cnt_fin};

  always_comb begin
    res.status        = status_r;
    res.count         = cnt_ext[srm_pkg::CNT_OUT_W-1:0];
    res.removed_value = (status_r == srm_pkg::ST_OK && act_r == srm_pkg::ACT_REMOVE) ?
                        best_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srm_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    act_r    <= act_nxt;
    best_r   <= best_nxt;
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
  end

endmodule
